@@ src/bfa_pkg.sv @@
package bfa_pkg;

  localparam int NUM_FRAMES  = 65536;
  localparam int CNT_W       = 17;
  localparam int ADDR_W      = 32;
  localparam int FRAME_SHIFT = 12;
  localparam int WORD_W      = 64;
  localparam int BIT_W       = $clog2(WORD_W);
  localparam int WORDS       = (NUM_FRAMES + WORD_W - 1) / WORD_W;
  localparam int WADDR_W     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IDX_W       = WADDR_W + BIT_W;

  localparam logic CFG_TOTAL    = 1'b0;
  localparam logic CFG_RESERVED = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    CMD_INIT    = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_FREE    = 2'd2,
    CMD_RESERVE = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOT_INIT = 2'd1,
    ST_NO_FREE  = 2'd2,
    ST_IGNORED  = 2'd3
  } st_code_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic init_wr;
    logic scan;
    logic alloc_wr;
    logic rmw_rd;
    logic rmw_upd;
    logic load_out;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic map_ready;
    logic active_zero;
    logic in_range;
    logic init_last;
    logic scan_hit;
    logic scan_miss;
    logic out_free;
  } stat_t;

  // bits of word w whose frame index is below lim
  function automatic word_t lt_mask(input logic [WADDR_W-1:0] w, input logic [CNT_W-1:0] lim);
    logic [31:0]      lw;
    logic [BIT_W-1:0] lo;
    word_t            m;
    lw = 32'(lim >> BIT_W);
    lo = lim[BIT_W-1:0];
    if (32'(w) < lw) m = '1;
    else if (32'(w) == lw) m = ~({WORD_W{1'b1}} << lo);
    else m = '0;
    return m;
  endfunction

  // bits of word w whose frame index is at or above lim
  function automatic word_t ge_mask(input logic [WADDR_W-1:0] w, input logic [CNT_W-1:0] lim);
    logic [31:0]      lw;
    logic [BIT_W-1:0] lo;
    word_t            m;
    lw = 32'(lim >> BIT_W);
    lo = lim[BIT_W-1:0];
    if (32'(w) > lw) m = '1;
    else if (32'(w) == lw) m = {WORD_W{1'b1}} << lo;
    else m = '0;
    return m;
  endfunction

  function automatic word_t low_bit(input word_t v);
    return v & (~v + word_t'(1));
  endfunction

  // index of a one-hot word
  function automatic logic [BIT_W-1:0] onehot_index(input word_t v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (v[i]) idx = idx | BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

@@ src/bfa_ram.sv @@
module bfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

@@ src/bfa_ctrl.sv @@
module bfa_ctrl import bfa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] command,
  input  stat_t      stat,
  output ctl_t       ctl
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_INIT     = 7'b0000010,
    S_SCAN     = 7'b0000100,
    S_ALLOC_WR = 7'b0001000,
    S_RMW_RD   = 7'b0010000,
    S_RMW_UPD  = 7'b0100000,
    S_FIN      = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.accept = 1'b1;
          case (command)
            CMD_INIT: state_next = S_INIT;
            CMD_ALLOC: begin
              if (stat.map_ready && !stat.active_zero) state_next = S_SCAN;
              else state_next = S_FIN;
            end
            default: begin
              if (stat.in_range) state_next = S_RMW_RD;
              else state_next = S_FIN;
            end
          endcase
        end
      end
      S_INIT: begin
        ctl.init_wr = 1'b1;
        if (stat.init_last) state_next = S_FIN;
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (stat.scan_hit) state_next = S_ALLOC_WR;
        else if (stat.scan_miss) state_next = S_FIN;
      end
      S_ALLOC_WR: begin
        ctl.alloc_wr = 1'b1;
        state_next   = S_FIN;
      end
      S_RMW_RD: begin
        ctl.rmw_rd = 1'b1;
        state_next = S_RMW_UPD;
      end
      S_RMW_UPD: begin
        ctl.rmw_upd = 1'b1;
        state_next  = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

@@ src/bfa_dp.sv @@
module bfa_dp import bfa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ctl_t              ctl,
  output stat_t             stat,
  input  logic [1:0]        command,
  input  logic [ADDR_W-1:0] address,
  input  logic              cfg_valid,
  input  logic              cfg_index,
  input  logic [CNT_W-1:0]  cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ADDR_W-1:0] frame_address,
  output logic [1:0]        status,
  output logic [CNT_W-1:0]  free_count
);

  logic [CNT_W-1:0]   total_cfg, reserved_frames;
  logic [CNT_W-1:0]   active, free_base;
  logic               map_ready;
  logic [CNT_W-1:0]   free_total;
  cmd_code_t          cur_cmd;
  logic [IDX_W-1:0]   cur_frame;
  logic [WADDR_W-1:0] ptr;
  logic               chk_v;
  logic [WADDR_W-1:0] chk_addr;
  logic [WADDR_W-1:0] hit_addr;
  logic [BIT_W-1:0]   hit_bit;
  word_t              hit_word;
  st_code_t           res_status;

  logic               ram_we, ram_re;
  logic [WADDR_W-1:0] ram_waddr, ram_raddr;
  word_t              ram_wdata, ram_rdata;

  logic [CNT_W-1:0]   lim_c, first_c, act_m1;
  logic               in_range;
  word_t              free_bits, lowest, init_word, bit_sel;
  logic               at_last, cur_used;
  logic [WADDR_W-1:0] cur_word;
  logic [BIT_W-1:0]   cur_bit;

  assign cur_word = cur_frame[IDX_W-1:BIT_W];
  assign cur_bit  = cur_frame[BIT_W-1:0];
  assign bit_sel  = word_t'(1) << cur_bit;
  assign cur_used = |(ram_rdata & bit_sel);

  assign lim_c   = (32'(total_cfg) > 32'(NUM_FRAMES)) ? CNT_W'(NUM_FRAMES) : total_cfg;
  assign first_c = (reserved_frames > lim_c) ? lim_c : reserved_frames;

  assign in_range  = ((address >> FRAME_SHIFT) < ADDR_W'(active));
  assign act_m1    = active - CNT_W'(1);
  assign at_last   = (32'(chk_addr) == 32'(act_m1 >> BIT_W));
  assign free_bits = ~ram_rdata & lt_mask(chk_addr, active);
  assign lowest    = low_bit(free_bits);
  assign init_word = ~(ge_mask(ptr, free_base) & lt_mask(ptr, active));

  always_comb begin
    stat.map_ready   = map_ready;
    stat.active_zero = (active == '0);
    stat.in_range    = in_range;
    stat.init_last   = (ptr == WADDR_W'(WORDS - 1));
    stat.scan_hit    = chk_v && (|free_bits);
    stat.scan_miss   = chk_v && !(|free_bits) && at_last;
    stat.out_free    = !out_valid || out_ready;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_word;
    ram_wdata = ram_rdata;
    if (ctl.init_wr) begin
      ram_we    = 1'b1;
      ram_waddr = ptr;
      ram_wdata = init_word;
    end else if (ctl.alloc_wr) begin
      ram_we    = 1'b1;
      ram_waddr = hit_addr;
      ram_wdata = hit_word;
    end else if (ctl.rmw_upd) begin
      if (cur_cmd == CMD_FREE) begin
        ram_we    = cur_used;
        ram_wdata = ram_rdata & ~bit_sel;
      end else begin
        ram_we    = !cur_used;
        ram_wdata = ram_rdata | bit_sel;
      end
    end
    ram_re    = ctl.scan || ctl.rmw_rd;
    ram_raddr = ctl.scan ? ptr : cur_word;
  end

  bfa_ram #(
    .WIDTH(WORD_W),
    .DEPTH(WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      total_cfg       <= CNT_W'(65536);
      reserved_frames <= CNT_W'(1024);
      active          <= '0;
      map_ready       <= 1'b0;
      free_total      <= '0;
      chk_v           <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_TOTAL) total_cfg <= cfg_data;
        else reserved_frames <= cfg_data;
      end
      if (ctl.accept) begin
        chk_v <= 1'b0;
        if (command == CMD_INIT) begin
          active     <= lim_c;
          free_total <= lim_c - first_c;
          map_ready  <= 1'b1;
        end
      end
      if (ctl.scan) chk_v <= 1'b1;
      if (ctl.alloc_wr && free_total != '0) free_total <= free_total - CNT_W'(1);
      if (ctl.rmw_upd) begin
        if (cur_cmd == CMD_FREE) begin
          if (cur_used) free_total <= free_total + CNT_W'(1);
        end else if (!cur_used && free_total != '0) begin
          free_total <= free_total - CNT_W'(1);
        end
      end
      if (ctl.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cur_cmd       <= cmd_code_t'(command);
      cur_frame     <= address[FRAME_SHIFT +: IDX_W];
      ptr           <= '0;
      frame_address <= frame_address;
      if (command == CMD_INIT) free_base <= first_c;
      case (command)
        CMD_ALLOC: begin
          if (!map_ready) res_status <= ST_NOT_INIT;
          else if (active == '0) res_status <= ST_NO_FREE;
          else res_status <= ST_DONE;
        end
        CMD_FREE, CMD_RESERVE: begin
          if (!in_range) res_status <= ST_IGNORED;
          else res_status <= ST_DONE;
        end
        default: res_status <= ST_DONE;
      endcase
    end
    if (ctl.init_wr) ptr <= ptr + WADDR_W'(1);
    if (ctl.scan) begin
      // reads run one word ahead of the check
      ptr      <= ptr + WADDR_W'(1);
      chk_addr <= ptr;
      if (chk_v && (|free_bits)) begin
        hit_addr <= chk_addr;
        hit_bit  <= onehot_index(lowest);
        hit_word <= ram_rdata | lowest;
      end else if (chk_v && at_last) begin
        res_status <= ST_NO_FREE;
      end
    end
    if (ctl.rmw_upd) begin
      if ((cur_cmd == CMD_FREE) != cur_used) res_status <= ST_IGNORED;
    end
    if (ctl.load_out) begin
      if (cur_cmd == CMD_ALLOC && res_status == ST_DONE) begin
        frame_address <= ADDR_W'({hit_addr, hit_bit}) << FRAME_SHIFT;
      end else begin
        frame_address <= '0;
      end
      status     <= res_status;
      free_count <= free_total;
    end
  end

endmodule

@@ src/bitmap_frame_allocator.sv @@
// Bitmap allocator for 4 KB physical frames, one used bit per frame.
// Command channel (in_valid/in_ready): command and byte address, a transfer
// when both are high. Result channel (out_valid/out_ready): frame_address,
// status and free_count, one result per command, in command order.
// Config channel (cfg_valid/cfg_ready): index 0 frame total, 1 reserved_frames;
// always ready, values take effect at the next init command.
// One command is in flight at a time. Work from accept to result valid:
//   init     a sweep writing one 64-bit map word per cycle over all WORDS
//   allocate a first-fit scan reading one word per cycle from word 0 up to the
//            first map word holding a free frame, then a write of that word
//   free / reserve a read-modify-write of one map word
//   none     allocate before init, zero-frame map, out-of-range free/reserve
// The next command is accepted as soon as its result sits in the output
// register; if the receiver stalls, the following command completes its work
// and then waits until the output register empties.
// Reset: map not ready, free count zero, registers at 65536 and 1024 frames;
// the map memory is not cleared, init rewrites every word.
module bitmap_frame_allocator import bfa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        command,
  input  logic [ADDR_W-1:0] address,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ADDR_W-1:0] frame_address,
  output logic [1:0]        status,
  output logic [CNT_W-1:0]  free_count,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [CNT_W-1:0]  cfg_data
);

  ctl_t  ctl;
  stat_t stat;

  assign cfg_ready = 1'b1;

  bfa_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command (command),
    .stat    (stat),
    .ctl     (ctl)
  );

  bfa_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .stat         (stat),
    .command      (command),
    .address      (address),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_address(frame_address),
    .status       (status),
    .free_count   (free_count)
  );

endmodule
